/* hdl/qmn_pkg.sv */
// Shared constants, types and sideband record for the normalized quaternion product.
// No dependencies; every other file of the block refers to this package by scoped name.
package qmn_pkg;

   localparam int FRAC_BITS  = 30;   // fraction bits of every component
   localparam int COMP_W     = 32;
   localparam int MAG_W      = 35;   // |rounded product component|
   localparam int MANT_W     = 30;   // normalized mantissa
   localparam int ROOT_W     = 32;   // isqrt result bits, one per stage
   localparam int NUM_W      = 64;   // divider dividend
   localparam int DEN_W      = 33;   // divider divisor
   localparam int QUO_W      = 34;   // divider quotient bits, one per stage
   localparam int BAND_W     = 31;
   localparam int SCALE_FRAC = 32;   // scale and quotients are Q.32

   localparam logic [BAND_W-1:0] BAND_RESET = 31'd1048576;
   localparam logic [NUM_W-1:0]  SCALE_NUM  = 64'h8000_0000_0000_0000;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic [MANT_W-1:0]        mant_type;
   typedef logic signed [6:0]        expo_type;
   typedef logic [QUO_W-1:0]         quo_type;

   // travels with an item from normalization to the output stage
   typedef struct packed {
      logic                  valid;
      logic                  zero;
      logic                  inband;
      logic [3:0]            neg;
      expo_type              e;
      mant_type [3:0]        n;
      logic [DEN_W-1:0]      den;
   } side_type;

   typedef struct packed {
      side_type              side;
      logic [NUM_W-1:0]      sq4;    // four times the mantissa sum of squares
   } front_type;

endpackage

/* hdl/quaternion_multiply_normalize.sv */
// Top level of the normalized quaternion product; instantiates qmn_front, qmn_isqrt,
// qmn_div and qmn_back, and uses qmn_pkg.
//
// Takes one item per clock while req_stall is low and returns one result per item, in
// order. The pipeline has 9 front stages (product, rounding, normalization,
// squared magnitude), 32 square-root stages and 34 divider stages (one result bit
// each), and 2 output stages. The whole pipeline freezes while a result sits on
// rsp_* with rsp_stall high; req_stall is that same condition. Write
// near_unit_band only while no item is in flight; csr_ready is always high.
module quaternion_multiply_normalize (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  qmn_pkg::comp_type             req_a_w,
   input  qmn_pkg::comp_type             req_a_x,
   input  qmn_pkg::comp_type             req_a_y,
   input  qmn_pkg::comp_type             req_a_z,
   input  qmn_pkg::comp_type             req_b_w,
   input  qmn_pkg::comp_type             req_b_x,
   input  qmn_pkg::comp_type             req_b_y,
   input  qmn_pkg::comp_type             req_b_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output qmn_pkg::comp_type             rsp_p_w,
   output qmn_pkg::comp_type             rsp_p_x,
   output qmn_pkg::comp_type             rsp_p_y,
   output qmn_pkg::comp_type             rsp_p_z,
   output logic                          rsp_zero_magnitude,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [qmn_pkg::BAND_W-1:0]    csr_near_unit_band
);

   logic                          en;
   logic [qmn_pkg::BAND_W-1:0]    band_ff;
   qmn_pkg::front_type            front;
   logic [qmn_pkg::ROOT_W-1:0]    root;
   qmn_pkg::side_type             line_a_ff [qmn_pkg::ROOT_W];
   qmn_pkg::side_type             line_b_ff [qmn_pkg::QUO_W];
   qmn_pkg::side_type             side_a;
   qmn_pkg::quo_type              scale;
   qmn_pkg::quo_type              quo [4];

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= qmn_pkg::BAND_RESET;
      end else if (csr_valid && csr_ready) begin
         band_ff <= csr_near_unit_band;
      end
   end

   qmn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .a_w      (req_a_w),
      .a_x      (req_a_x),
      .a_y      (req_a_y),
      .a_z      (req_a_z),
      .b_w      (req_b_w),
      .b_x      (req_b_x),
      .b_y      (req_b_y),
      .b_z      (req_b_z),
      .band     (band_ff),
      .front    (front)
   );

   qmn_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (front.sq4),
      .root     (root)
   );

   // sideband follows the item through the root and divider pipelines
   always_ff @(posedge clock) begin
      if (en) begin
         line_a_ff[0] <= front.side;
         for (int i = 1; i < qmn_pkg::ROOT_W; i++) begin
            line_a_ff[i] <= line_a_ff[i-1];
         end
         line_b_ff[0] <= line_a_ff[qmn_pkg::ROOT_W-1];
         for (int i = 1; i < qmn_pkg::QUO_W; i++) begin
            line_b_ff[i] <= line_b_ff[i-1];
         end
      end
      if (reset) begin
         for (int i = 0; i < qmn_pkg::ROOT_W; i++) begin
            line_a_ff[i].valid <= 1'b0;
         end
         for (int i = 0; i < qmn_pkg::QUO_W; i++) begin
            line_b_ff[i].valid <= 1'b0;
         end
      end
   end

   assign side_a = line_a_ff[qmn_pkg::ROOT_W-1];

   // 2^63 / ((1 + m2) in Q.30)
   qmn_div u_scale (
      .clock    (clock),
      .en       (en),
      .dividend (qmn_pkg::SCALE_NUM),
      .divisor  (side_a.den),
      .quotient (scale)
   );

   // n * 2^33 / isqrt(4N), one divider per component
   for (genvar g = 0; g < 4; g++) begin : g_comp
      qmn_div u_quo (
         .clock    (clock),
         .en       (en),
         .dividend ({1'b0, side_a.n[g], 33'b0}),
         .divisor  ({1'b0, root}),
         .quotient (quo[g])
      );
   end

   qmn_back u_back (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .side           (line_b_ff[qmn_pkg::QUO_W-1]),
      .scale          (scale),
      .quo            (quo),
      .out_valid      (rsp_valid),
      .p_w            (rsp_p_w),
      .p_x            (rsp_p_x),
      .p_y            (rsp_p_y),
      .p_z            (rsp_p_z),
      .zero_magnitude (rsp_zero_magnitude)
   );

endmodule

/* hdl/qmn_front.sv */
// Front pipeline: Hamilton product, rounding, block normalization, squared magnitude,
// band test and reciprocal divisor. Nine register stages. Uses qmn_pkg.
module qmn_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  qmn_pkg::comp_type             a_w,
   input  qmn_pkg::comp_type             a_x,
   input  qmn_pkg::comp_type             a_y,
   input  qmn_pkg::comp_type             a_z,
   input  qmn_pkg::comp_type             b_w,
   input  qmn_pkg::comp_type             b_x,
   input  qmn_pkg::comp_type             b_y,
   input  qmn_pkg::comp_type             b_z,
   input  logic [qmn_pkg::BAND_W-1:0]    band,
   output qmn_pkg::front_type            front
);

   localparam logic [62:0] ONE_Q60 = 63'h1000_0000_0000_0000;

   // floor((+/-)x*y / 4)
   function automatic logic signed [63:0] term_of(input qmn_pkg::comp_type x,
                                                  input qmn_pkg::comp_type y,
                                                  input logic sub);
      logic signed [63:0] p;
      logic signed [63:0] t;
      begin
         p = x * y;
         t = sub ? -p : p;
         return t >>> 2;
      end
   endfunction

   // stage 1: products
   logic                    s1_valid_ff;
   logic signed [63:0]      s1_term_ff [16];
   // stage 2: sums
   logic                    s2_valid_ff;
   logic signed [63:0]      s2_h_ff [4];
   // stage 3: rounded magnitudes
   logic                    s3_valid_ff;
   logic [qmn_pkg::MAG_W-1:0] s3_mag_ff [4];
   logic [3:0]              s3_neg_ff;
   // stage 4: largest magnitude
   logic                    s4_valid_ff;
   logic [qmn_pkg::MAG_W-1:0] s4_mag_ff [4];
   logic [3:0]              s4_neg_ff;
   logic [qmn_pkg::MAG_W-1:0] s4_mx_ff;
   // stages 5..8
   qmn_pkg::side_type       s5_ff, s6_ff, s7_ff, s8_ff;
   logic [59:0]             s6_sq_ff [4];
   logic [61:0]             s7_big_ff;
   logic [61:0]             s8_big_ff;
   logic [62:0]             s8_m2q_ff;
   qmn_pkg::front_type      front_ff;

   logic signed [63:0]      h_in [4];
   logic [qmn_pkg::MAG_W-1:0] mag_in [4];
   logic [3:0]              neg_in;
   logic [qmn_pkg::MAG_W-1:0] mx01, mx23, mx_in;
   qmn_pkg::side_type       s5_in;
   logic [5:0]              len;
   logic [62:0]             m2q_in;
   logic [71:0]             m2q_wide;
   logic [6:0]              e_neg;
   qmn_pkg::side_type       s9_in;
   logic [62:0]             diff;
   logic [63:0]             one_plus;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_valid_ff    <= in_valid;
         s1_term_ff[0]  <= term_of(b_w, a_w, 1'b0);
         s1_term_ff[1]  <= term_of(a_x, b_x, 1'b1);
         s1_term_ff[2]  <= term_of(a_y, b_y, 1'b1);
         s1_term_ff[3]  <= term_of(a_z, b_z, 1'b1);
         s1_term_ff[4]  <= term_of(b_w, a_x, 1'b0);
         s1_term_ff[5]  <= term_of(a_w, b_x, 1'b0);
         s1_term_ff[6]  <= term_of(a_y, b_z, 1'b0);
         s1_term_ff[7]  <= term_of(a_z, b_y, 1'b1);
         s1_term_ff[8]  <= term_of(b_w, a_y, 1'b0);
         s1_term_ff[9]  <= term_of(a_w, b_y, 1'b0);
         s1_term_ff[10] <= term_of(a_z, b_x, 1'b0);
         s1_term_ff[11] <= term_of(a_x, b_z, 1'b1);
         s1_term_ff[12] <= term_of(b_w, a_z, 1'b0);
         s1_term_ff[13] <= term_of(a_w, b_z, 1'b0);
         s1_term_ff[14] <= term_of(a_x, b_y, 1'b0);
         s1_term_ff[15] <= term_of(a_y, b_x, 1'b1);
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         h_in[i] = s1_term_ff[4*i] + s1_term_ff[4*i+1] + s1_term_ff[4*i+2]
                 + s1_term_ff[4*i+3];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_valid_ff <= s1_valid_ff;
         s2_h_ff     <= h_in;
      end
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end
   end

   // round to FRAC_BITS fraction bits, then split sign and magnitude
   always_comb begin
      logic signed [63:0] rnd;
      logic signed [35:0] p;
      for (int i = 0; i < 4; i++) begin
         rnd       = (s2_h_ff[i] + (64'sd1 <<< (qmn_pkg::FRAC_BITS - 3)))
                     >>> (qmn_pkg::FRAC_BITS - 2);
         p         = rnd[35:0];
         neg_in[i] = p[35];
         mag_in[i] = p[35] ? qmn_pkg::MAG_W'(-p) : qmn_pkg::MAG_W'(p);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_valid_ff <= s2_valid_ff;
         s3_mag_ff   <= mag_in;
         s3_neg_ff   <= neg_in;
      end
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      mx01  = (s3_mag_ff[0] > s3_mag_ff[1]) ? s3_mag_ff[0] : s3_mag_ff[1];
      mx23  = (s3_mag_ff[2] > s3_mag_ff[3]) ? s3_mag_ff[2] : s3_mag_ff[3];
      mx_in = (mx01 > mx23) ? mx01 : mx23;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_valid_ff <= s3_valid_ff;
         s4_mag_ff   <= s3_mag_ff;
         s4_neg_ff   <= s3_neg_ff;
         s4_mx_ff    <= mx_in;
      end
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end
   end

   // shift all magnitudes so the largest has exactly MANT_W bits
   always_comb begin
      len = '0;
      for (int i = 0; i < qmn_pkg::MAG_W; i++) begin
         if (s4_mx_ff[i]) begin
            len = 6'(i + 1);
         end
      end
      s5_in.valid  = s4_valid_ff;
      s5_in.zero   = (s4_mx_ff == '0);
      s5_in.inband = 1'b0;
      s5_in.neg    = s4_neg_ff;
      s5_in.e      = $signed({1'b0, len}) - 7'sd30;
      s5_in.den    = '0;
      for (int i = 0; i < 4; i++) begin
         if (len >= 6'd30) begin
            s5_in.n[i] = qmn_pkg::MANT_W'(s4_mag_ff[i] >> (len - 6'd30));
         end else begin
            s5_in.n[i] = qmn_pkg::MANT_W'({30'b0, s4_mag_ff[i]} << (6'd30 - len));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_ff <= s5_in;
         s6_ff <= s5_ff;
         for (int i = 0; i < 4; i++) begin
            s6_sq_ff[i] <= 60'(s5_ff.n[i]) * 60'(s5_ff.n[i]);
         end
         s7_ff     <= s6_ff;
         s7_big_ff <= 62'(s6_sq_ff[0]) + 62'(s6_sq_ff[1]) + 62'(s6_sq_ff[2])
                    + 62'(s6_sq_ff[3]);
         s8_ff     <= s7_ff;
         s8_big_ff <= s7_big_ff;
         s8_m2q_ff <= m2q_in;
      end
      if (reset) begin
         s5_ff.valid <= 1'b0;
         s6_ff.valid <= 1'b0;
         s7_ff.valid <= 1'b0;
         s8_ff.valid <= 1'b0;
      end
   end

   // squared magnitude as Q.60, saturating at 4.0
   always_comb begin
      e_neg    = 7'(-s7_ff.e);
      m2q_wide = {10'b0, s7_big_ff} << {s7_ff.e[3:0], 1'b0};
      if (s7_ff.e <= 7'sd0) begin
         m2q_in = 63'(s7_big_ff >> {e_neg[4:0], 1'b0});
      end else if (|m2q_wide[71:62]) begin
         m2q_in = 63'h4000_0000_0000_0000;
      end else begin
         m2q_in = m2q_wide[62:0];
      end
   end

   always_comb begin
      diff         = (s8_m2q_ff >= ONE_Q60) ? (s8_m2q_ff - ONE_Q60) : (ONE_Q60 - s8_m2q_ff);
      one_plus     = {1'b0, ONE_Q60} + {1'b0, s8_m2q_ff};
      s9_in        = s8_ff;
      s9_in.inband = (diff < {2'b0, band, 30'b0});
      s9_in.den    = one_plus[62:30];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_ff.side <= s9_in;
         front_ff.sq4  <= {s8_big_ff, 2'b00};
      end
      if (reset) begin
         front_ff.side.valid <= 1'b0;
      end
   end

   assign front = front_ff;

endmodule

/* hdl/qmn_isqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Uses qmn_pkg for the result width.
module qmn_isqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [63:0]                   radicand,
   output logic [qmn_pkg::ROOT_W-1:0]    root
);

   logic [63:0] v_ff [qmn_pkg::ROOT_W];
   logic [63:0] r_ff [qmn_pkg::ROOT_W];

   for (genvar g = 0; g < qmn_pkg::ROOT_W; g++) begin : g_step
      localparam logic [63:0] BIT = 64'h1 << (2*qmn_pkg::ROOT_W - 2 - 2*g);
      logic [63:0] v_cur, r_cur, v_in, r_in;
      logic [64:0] trial;

      if (g == 0) begin : g_first
         assign v_cur = radicand;
         assign r_cur = '0;
      end else begin : g_next
         assign v_cur = v_ff[g-1];
         assign r_cur = r_ff[g-1];
      end

      always_comb begin
         trial = {1'b0, r_cur} + {1'b0, BIT};
         if ({1'b0, v_cur} >= trial) begin
            v_in = v_cur - trial[63:0];
            r_in = (r_cur >> 1) + BIT;
         end else begin
            v_in = v_cur;
            r_in = r_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[g] <= v_in;
            r_ff[g] <= r_in;
         end
      end
   end

   assign root = r_ff[qmn_pkg::ROOT_W-1][qmn_pkg::ROOT_W-1:0];

endmodule

/* hdl/qmn_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// The dividend's top bits must be below the divisor. Uses qmn_pkg for widths.
module qmn_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [qmn_pkg::NUM_W-1:0]     dividend,
   input  logic [qmn_pkg::DEN_W-1:0]     divisor,
   output qmn_pkg::quo_type              quotient
);

   localparam int QW = qmn_pkg::QUO_W;
   localparam int DW = qmn_pkg::DEN_W;

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] q_ff   [QW];

   for (genvar g = 0; g < QW; g++) begin : g_step
      logic [DW-1:0] rem_cur, den_cur, rem_in;
      logic [QW-1:0] low_cur, q_cur;
      logic [DW:0]   trial;
      logic          qbit;

      if (g == 0) begin : g_first
         assign rem_cur = DW'(dividend[qmn_pkg::NUM_W-1:QW]);
         assign low_cur = dividend[QW-1:0];
         assign den_cur = divisor;
         assign q_cur   = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[g-1];
         assign low_cur = low_ff[g-1];
         assign den_cur = den_ff[g-1];
         assign q_cur   = q_ff[g-1];
      end

      always_comb begin
         trial = {rem_cur, low_cur[QW-1]};
         qbit  = (trial >= {1'b0, den_cur});
         if (qbit) begin
            rem_in = DW'(trial - {1'b0, den_cur});
         end else begin
            rem_in = trial[DW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= rem_in;
            low_ff[g] <= {low_cur[QW-2:0], 1'b0};
            den_ff[g] <= den_cur;
            q_ff[g]   <= {q_cur[QW-2:0], qbit};
         end
      end
   end

   assign quotient = q_ff[QW-1];

endmodule

/* hdl/qmn_back.sv */
// Output end: scale multiply for the near-unit path, rounding, sign and saturation,
// and the result register. Uses qmn_pkg.
module qmn_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  qmn_pkg::side_type    side,
   input  qmn_pkg::quo_type     scale,
   input  qmn_pkg::quo_type     quo [4],
   output logic                 out_valid,
   output qmn_pkg::comp_type    p_w,
   output qmn_pkg::comp_type    p_x,
   output qmn_pkg::comp_type    p_y,
   output qmn_pkg::comp_type    p_z,
   output logic                 zero_magnitude
);

   localparam logic [37:0] LIM_POS = 38'h0_7FFF_FFFF;
   localparam logic [37:0] LIM_NEG = 38'h0_8000_0000;
   localparam int          Q_SHIFT = qmn_pkg::SCALE_FRAC - qmn_pkg::FRAC_BITS;

   qmn_pkg::side_type  b1_ff;
   logic [63:0]        prod_ff [4];
   qmn_pkg::quo_type   q1_ff [4];

   logic                out_valid_ff;
   qmn_pkg::comp_type   p_ff [4];
   logic                zero_ff;

   qmn_pkg::comp_type   p_in [4];
   logic signed [7:0]   k_wide;
   logic [5:0]          k;

   always_ff @(posedge clock) begin
      if (en) begin
         b1_ff <= side;
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= 64'(side.n[i]) * 64'(scale);
         end
         q1_ff <= quo;
      end
      if (reset) begin
         b1_ff.valid <= 1'b0;
      end
   end

   // right shift with round half up, then clamp to the signed range
   always_comb begin
      logic [37:0] m;
      k_wide = 8'(qmn_pkg::SCALE_FRAC) - {b1_ff.e[6], b1_ff.e};
      k      = k_wide[5:0];
      for (int i = 0; i < 4; i++) begin
         if (b1_ff.inband) begin
            m = 38'(prod_ff[i] >> k) + 38'(prod_ff[i][k - 6'd1]);
         end else begin
            m = 38'(q1_ff[i] >> Q_SHIFT) + 38'(q1_ff[i][Q_SHIFT-1]);
         end
         if (b1_ff.neg[i] && m > LIM_NEG) begin
            m = LIM_NEG;
         end else if (!b1_ff.neg[i] && m > LIM_POS) begin
            m = LIM_POS;
         end
         if (b1_ff.zero) begin
            p_in[i] = '0;
         end else if (b1_ff.neg[i]) begin
            p_in[i] = 32'd0 - m[31:0];
         end else begin
            p_in[i] = m[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_valid_ff <= b1_ff.valid;
         p_ff         <= p_in;
         zero_ff      <= b1_ff.zero;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign out_valid      = out_valid_ff;
   assign p_w            = p_ff[0];
   assign p_x            = p_ff[1];
   assign p_y            = p_ff[2];
   assign p_z            = p_ff[3];
   assign zero_magnitude = zero_ff;

endmodule

/* hdl/qmn_check.sv */
// Port-level checks for quaternion_multiply_normalize, and the bind that attaches them.
// Depends on qmn_pkg and the top level's port list.
module qmn_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input qmn_pkg::comp_type             rsp_p_w,
   input qmn_pkg::comp_type             rsp_p_x,
   input qmn_pkg::comp_type             rsp_p_y,
   input qmn_pkg::comp_type             rsp_p_z,
   input logic                          rsp_zero_magnitude
);

   // a waiting result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_p_w) && $stable(rsp_p_x)
         && $stable(rsp_p_y) && $stable(rsp_p_z) && $stable(rsp_zero_magnitude))
      else $error("result changed while stalled");

   // input is held back only by a blocked result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   // zero magnitude forces all components to zero
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_magnitude |->
         rsp_p_w == '0 && rsp_p_x == '0 && rsp_p_y == '0 && rsp_p_z == '0)
      else $error("zero magnitude with nonzero component");

   // no result right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind quaternion_multiply_normalize qmn_check u_qmn_check (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_p_w            (rsp_p_w),
   .rsp_p_x            (rsp_p_x),
   .rsp_p_y            (rsp_p_y),
   .rsp_p_z            (rsp_p_z),
   .rsp_zero_magnitude (rsp_zero_magnitude)
);

/* verif/quaternion_multiply_normalize_test.sv */
// Testbench for quaternion_multiply_normalize: drives quaternion pairs and checks every
// normalized product against a behavioral predictor, queued in a small scoreboard class.
// Depends on qmn_pkg and the quaternion_multiply_normalize RTL only.
`timescale 1ns / 100ps

module quaternion_multiply_normalize_test;

   typedef struct {
      qmn_pkg::comp_type a [4];   // w, x, y, z
      qmn_pkg::comp_type b [4];
   } quat_pair_type;

   typedef struct {
      qmn_pkg::comp_type p [4];
      logic              zero;
   } product_type;

   localparam logic [qmn_pkg::BAND_W-1:0] BAND_MAX = 31'h7FFF_FFFF;
   localparam logic [qmn_pkg::BAND_W-1:0] BAND_HALF_RANGE = 31'd1073741824;
   localparam qmn_pkg::comp_type ONE = 32'sh4000_0000;
   localparam qmn_pkg::comp_type MAXV = 32'sh7FFF_FFFF;
   localparam qmn_pkg::comp_type MINV = 32'sh8000_0000;

   // ---------------------------------------------------------------- predictor
   function automatic longint hterm(qmn_pkg::comp_type x, qmn_pkg::comp_type y, bit sub);
      longint p;
      p = longint'(x) * longint'(y);
      if (sub)
         p = -p;
      return p >>> 2;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, probe;
      r = 0;
      probe = 64'd1 << 62;
      while (probe > v)
         probe >>= 2;
      while (probe != 0) begin
         if (v >= r + probe) begin
            v -= r + probe;
            r = (r >> 1) + probe;
         end else begin
            r >>= 1;
         end
         probe >>= 2;
      end
      return r;
   endfunction

   function automatic qmn_pkg::comp_type round_saturate(longint unsigned mag, int sh,
                                                        bit neg);
      longint unsigned lim, m;
      int k;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (sh >= 0) begin
         if (mag == 0)
            m = 0;
         else if (sh >= 32 || mag > (lim >> sh))
            m = lim;
         else
            m = mag << sh;
      end else begin
         k = -sh;
         if (k > 63)
            m = 0;
         else
            m = (mag >> k) + ((mag >> (k - 1)) & 64'd1);
         if (m > lim)
            m = lim;
      end
      if (neg)
         m = ~m + 64'd1;
      return qmn_pkg::comp_type'(m[31:0]);
   endfunction

   function automatic product_type predict_product(quat_pair_type q,
                                                   logic [qmn_pkg::BAND_W-1:0] band);
      product_type res;
      longint h [4];
      longint pr;
      longint unsigned mag [4], n [4];
      longint unsigned mx, big, m2q, band60, s, r, one;
      bit neg [4];
      bit inband;
      int len, e, sh;
      one = 64'd1 << 60;
      mx = 0;
      big = 0;
      len = 0;
      h[0] = hterm(q.b[0], q.a[0], 0) + hterm(q.a[1], q.b[1], 1) + hterm(q.a[2], q.b[2], 1)
           + hterm(q.a[3], q.b[3], 1);
      h[1] = hterm(q.b[0], q.a[1], 0) + hterm(q.a[0], q.b[1], 0) + hterm(q.a[2], q.b[3], 0)
           + hterm(q.a[3], q.b[2], 1);
      h[2] = hterm(q.b[0], q.a[2], 0) + hterm(q.a[0], q.b[2], 0) + hterm(q.a[3], q.b[1], 0)
           + hterm(q.a[1], q.b[3], 1);
      h[3] = hterm(q.b[0], q.a[3], 0) + hterm(q.a[0], q.b[3], 0) + hterm(q.a[1], q.b[2], 0)
           + hterm(q.a[2], q.b[1], 1);
      for (int i = 0; i < 4; i++) begin
         pr = (h[i] + 64'sd134217728) >>> (qmn_pkg::FRAC_BITS - 2);
         neg[i] = pr < 0;
         mag[i] = neg[i] ? longint'(-pr) : pr;
         if (mag[i] > mx)
            mx = mag[i];
      end
      res.zero = (mx == 0);
      if (res.zero) begin
         for (int i = 0; i < 4; i++)
            res.p[i] = '0;
         return res;
      end
      while (len < 64 && (mx >> len) != 0)
         len++;
      e = len - 30;
      for (int i = 0; i < 4; i++) begin
         n[i] = (e >= 0) ? (mag[i] >> e) : (mag[i] << (-e));
         big += n[i] * n[i];
      end
      // m2 in Q.60, saturating at four
      if (e <= 0) begin
         sh = -2 * e;
         m2q = (sh >= 64) ? 64'd0 : (big >> sh);
      end else begin
         sh = 2 * e;
         if (sh > 62 || big >= (64'd1 << (62 - sh)))
            m2q = 64'd1 << 62;
         else
            m2q = big << sh;
      end
      band60 = longint'(band) << 30;
      inband = (m2q >= one) ? (m2q - one < band60) : (one - m2q < band60);
      if (inband) begin
         s = (64'd1 << 63) / ((one + m2q) >> 30);
         for (int i = 0; i < 4; i++)
            res.p[i] = round_saturate(n[i] * s, e - 32, neg[i]);
      end else begin
         r = int_sqrt(big << 2);
         for (int i = 0; i < 4; i++)
            res.p[i] = round_saturate((n[i] << 33) / r, qmn_pkg::FRAC_BITS - 32, neg[i]);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- scoreboard
   class product_scoreboard;
      product_type pending_products [$];
      int mismatches;

      function new();
         mismatches = 0;
      endfunction

      function void note_request(quat_pair_type q, logic [qmn_pkg::BAND_W-1:0] band);
         pending_products.push_back(predict_product(q, band));
      endfunction

      function void check_result(product_type got);
         product_type want;
         bit bad;
         if (pending_products.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected product: %h %h %h %h zero=%b",
                        got.p[0], got.p[1], got.p[2], got.p[3], got.zero);
            return;
         end
         want = pending_products.pop_front();
         bad = (got.zero !== want.zero);
         for (int i = 0; i < 4; i++)
            if (got.p[i] !== want.p[i])
               bad = 1;
         if (bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display("product mismatch: expected %h %h %h %h zero=%b, got %h %h %h %h zero=%b",
                        want.p[0], want.p[1], want.p[2], want.p[3], want.zero,
                        got.p[0], got.p[1], got.p[2], got.p[3], got.zero);
         end
      endfunction
   endclass

   // ---------------------------------------------------------------- DUT
   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, rsp_zero_magnitude;
   logic csr_valid, csr_ready;
   logic [qmn_pkg::BAND_W-1:0] csr_near_unit_band;
   qmn_pkg::comp_type req_a [4], req_b [4], rsp_p [4];

   quaternion_multiply_normalize dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_a_w            (req_a[0]),
      .req_a_x            (req_a[1]),
      .req_a_y            (req_a[2]),
      .req_a_z            (req_a[3]),
      .req_b_w            (req_b[0]),
      .req_b_x            (req_b[1]),
      .req_b_y            (req_b[2]),
      .req_b_z            (req_b[3]),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_p_w            (rsp_p[0]),
      .rsp_p_x            (rsp_p[1]),
      .rsp_p_y            (rsp_p[2]),
      .rsp_p_z            (rsp_p[3]),
      .rsp_zero_magnitude (rsp_zero_magnitude),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_near_unit_band (csr_near_unit_band)
   );

   product_scoreboard products = new();
   logic [qmn_pkg::BAND_W-1:0] band_shadow = qmn_pkg::BAND_RESET;
   bit calm = 0;           // no idling on either side
   int hold_requests = 0;  // bumped to ask the receiver for a long hold-off

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver
   initial begin
      int hold_left, hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = !calm && ($urandom_range(99) < 28);
         end
      end
   end

   always @(posedge clock) begin
      product_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.p = rsp_p;
         got.zero = rsp_zero_magnitude;
         products.check_result(got);
      end
   end

   // ---------------------------------------------------------------- driving
   task automatic send_pair(quat_pair_type q);
      while (!calm && $urandom_range(99) < 28) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_a = q.a;
      req_b = q.b;
      req_valid = 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      products.note_request(q, band_shadow);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (products.pending_products.size() != 0)
         @(posedge clock);
      repeat (90) @(posedge clock);
   endtask

   task automatic write_band(logic [qmn_pkg::BAND_W-1:0] value);
      @(negedge clock);
      csr_near_unit_band = value;
      csr_valid = 1'b1;
      do
         @(posedge clock);
      while (!csr_ready);
      band_shadow = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic quat_pair_type make_pair(
      qmn_pkg::comp_type aw, qmn_pkg::comp_type ax, qmn_pkg::comp_type ay,
      qmn_pkg::comp_type az, qmn_pkg::comp_type bw, qmn_pkg::comp_type bx,
      qmn_pkg::comp_type by, qmn_pkg::comp_type bz);
      quat_pair_type q;
      q.a = '{aw, ax, ay, az};
      q.b = '{bw, bx, by, bz};
      return q;
   endfunction

   function automatic qmn_pkg::comp_type wiggle(int k);
      return qmn_pkg::comp_type'(int'($urandom_range(2 ** (k + 1))) - 2 ** k);
   endfunction

   // one quaternion near unit length, dominant axis and sign at random
   function automatic void near_unit(ref qmn_pkg::comp_type c [4], input int k);
      int axis;
      axis = $urandom_range(3);
      for (int i = 0; i < 4; i++)
         c[i] = wiggle(k);
      c[axis] = ($urandom_range(1) ? ONE : -ONE) + wiggle(k);
   endfunction

   function automatic quat_pair_type random_pair();
      quat_pair_type q;
      int kind, sh;
      kind = $urandom_range(9);
      for (int i = 0; i < 4; i++) begin
         q.a[i] = qmn_pkg::comp_type'($urandom);
         q.b[i] = qmn_pkg::comp_type'($urandom);
      end
      case (kind)
         2, 3, 4, 5: begin
            near_unit(q.a, $urandom_range(20));
            near_unit(q.b, $urandom_range(20));
         end
         6: begin
            sh = $urandom_range(31);
            for (int i = 0; i < 4; i++) begin
               q.a[i] = q.a[i] >>> sh;
               q.b[i] = q.b[i] >>> $urandom_range(31);
            end
         end
         7: begin
            // product rounds to zero or nearly so
            for (int i = 0; i < 4; i++) begin
               q.a[i] = wiggle($urandom_range(14));
               q.b[i] = wiggle($urandom_range(14));
            end
         end
         8: begin
            for (int i = 0; i < 4; i++) begin
               q.a[i] = $urandom_range(1) ? MAXV : ($urandom_range(1) ? MINV : '0);
               q.b[i] = $urandom_range(1) ? MAXV : ($urandom_range(1) ? MINV : '0);
            end
         end
         9: begin
            near_unit(q.a, 29);
            near_unit(q.b, $urandom_range(29));
         end
         default: ;
      endcase
      return q;
   endfunction

   // ---------------------------------------------------------------- stimulus
   initial begin
      logic [qmn_pkg::BAND_W-1:0] bands [7];
      quat_pair_type directed [$];
      reset = 1'b1;
      req_valid = 1'b0;
      csr_valid = 1'b0;
      csr_near_unit_band = '0;
      for (int i = 0; i < 4; i++) begin
         req_a[i] = '0;
         req_b[i] = '0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      bands = '{qmn_pkg::BAND_RESET, BAND_HALF_RANGE, 31'd0, 31'd1, BAND_MAX,
                31'($urandom_range(1, 1 << 24)), qmn_pkg::BAND_RESET};

      directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_pair(ONE, 0, 0, 0, ONE, 0, 0, 0));
      directed.push_back(make_pair(0, ONE, 0, 0, 0, 0, ONE, 0));
      directed.push_back(make_pair(0, 0, ONE, 0, 0, 0, 0, -ONE));
      directed.push_back(make_pair(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
      directed.push_back(make_pair(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
      directed.push_back(make_pair(MINV, 0, 0, 0, MINV, 0, 0, 0));
      directed.push_back(make_pair(MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, MAXV));
      directed.push_back(make_pair(1, 1, 1, 1, 1, 1, 1, 1));
      directed.push_back(make_pair(1, 0, 0, 0, 32'sd268435456, 0, 0, 0));
      directed.push_back(make_pair(ONE, 0, 0, 0, 32'sd256, 0, 0, 0));
      directed.push_back(make_pair(32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000,
                                   32'sh2000_0000, ONE, 0, 0, 0));
      directed.push_back(make_pair(ONE + 32'sd1000, 0, 0, 0, ONE, 0, 0, 0));
      directed.push_back(make_pair(ONE + 32'sd2000000, 0, 0, 0, ONE, 0, 0, 0));
      directed.push_back(make_pair(-ONE, 32'sd12345, -32'sd777, 32'sd5, ONE, 0, 0, 32'sd99));
      directed.push_back(make_pair(0, 0, 0, MAXV, 0, MAXV, 0, 0));
      directed.push_back(make_pair(32'sh1000_0000, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));

      for (int ph = 0; ph < 7; ph++) begin
         if (ph != 0) begin
            drain();
            write_band(bands[ph]);
         end
         if (ph == 0 || ph == 2 || ph == 3)
            foreach (directed[i])
               send_pair(directed[i]);
         calm = (ph == 4);
         for (int i = 0; i < 290; i++) begin
            if (ph == 1 && i == 50)
               hold_requests++;
            if (ph == 5 && i == 100) begin
               @(negedge clock);
               req_valid = 1'b0;
               while (products.pending_products.size() != 0)
                  @(posedge clock);
            end
            send_pair(random_pair());
         end
         calm = 0;
      end
      drain();

      if (products.mismatches == 0 && products.pending_products.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
